FILE: rtl/core/ata_pkg.sv
// Shared constants, types and the arctangent step table of the tilt angle pipeline.
`timescale 1ns / 1ps

package ata_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int CR_STEPS     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	localparam int SAMPLE_W = 16;
	localparam int ANGLE_W  = 16;
	localparam int IN_W     = 3 * SAMPLE_W;
	localparam int OUT_W    = 2 * ANGLE_W;

	// Square of a sample is at most 2^30, the sum of two squares at most 2^31.
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int SUM_W      = 2 * SAMPLE_W;
	// The radicand carries 16 extra fraction bits; its root has half the bits.
	localparam int RAD_W      = SUM_W + 16;
	localparam int RT_W       = RAD_W / 2;
	localparam int RM_W       = RT_W + 1;
	localparam int SQRT_STEPS = RT_W;

	// Vector components stay below 1.65 times the hypotenuse, well inside 27 bits.
	localparam int VEC_W  = 27;
	localparam int ANG_W  = 25;
	localparam int ATAN_W = 23;
	localparam int SH_W   = ANG_W - 7;

	localparam int DEG_LIMIT = 23040;

	// Squares, sum, one stage per root bit, one per rotation, then the output stage.
	localparam int LATENCY = 2 + SQRT_STEPS + CR_STEPS + 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ANGLE_W-1:0]  angle_t;

	// atan(2^-i) in degrees with 16 fraction bits.
	localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
		23'd234379,  23'd117304,  23'd58666,  23'd29335,
		23'd14668,   23'd7334,    23'd3667,   23'd1833,
		23'd917,     23'd458,     23'd229,    23'd115,
		23'd57,      23'd29,      23'd14,     23'd7,
		23'd4,       23'd2,       23'd1,      23'd0
	};

endpackage

FILE: rtl/core/ata_tilt.sv
// One tilt angle pipeline: sum of squares, digit-by-digit square root, vectoring CORDIC.
`timescale 1ns / 1ps

module ata_tilt (
	input  logic             clk,
	input  logic             en,
	input  ata_pkg::sample_t p,
	input  ata_pkg::sample_t a,
	input  ata_pkg::sample_t b,
	output ata_pkg::angle_t  rot
);
	import ata_pkg::*;

	localparam logic signed [ANG_W:0]  HALF_LSB = (ANG_W + 1)'(128);
	localparam logic signed [SH_W-1:0] HI_LIM   = SH_W'(DEG_LIMIT);
	localparam logic signed [SH_W-1:0] LO_LIM   = -HI_LIM;

	logic signed [2*SAMPLE_W-1:0] prod_a;
	logic signed [2*SAMPLE_W-1:0] prod_b;

	logic [SQ_W-1:0]  sq_a_s1;
	logic [SQ_W-1:0]  sq_b_s1;
	sample_t          p_s1;
	logic             zero_s1;
	logic [SUM_W-1:0] sum_s2;
	sample_t          p_s2;
	logic             zero_s2;

	// Square root stages, one root bit each.
	logic [RT_W-1:0]  root_sq_s [SQRT_STEPS];
	logic [RM_W-1:0]  rem_sq_s  [SQRT_STEPS];
	logic [SUM_W-1:0] sum_sq_s  [SQRT_STEPS];
	sample_t          p_sq_s    [SQRT_STEPS];
	logic             zero_sq_s [SQRT_STEPS];

	// Rotation stages; the last one keeps only the angle.
	logic signed [VEC_W-1:0] cx_cr_s   [CR_STEPS-1];
	logic signed [VEC_W-1:0] cy_cr_s   [CR_STEPS-1];
	logic signed [ANG_W-1:0] ang_cr_s  [CR_STEPS];
	logic                    zero_cr_s [CR_STEPS];

	logic signed [ANG_W:0]  neg_ang;
	logic signed [SH_W-1:0] deg_sh;
	angle_t                 rot_slast;

	assign prod_a = a * a;
	assign prod_b = b * b;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s1 <= prod_a[SQ_W-1:0];
			sq_b_s1 <= prod_b[SQ_W-1:0];
			p_s1    <= p;
			zero_s1 <= (p == '0);
			sum_s2  <= SUM_W'(sq_a_s1) + SUM_W'(sq_b_s1);
			p_s2    <= p_s1;
			zero_s2 <= zero_s1;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [RT_W-1:0]  root_in;
		logic [RM_W-1:0]  rem_in;
		logic [SUM_W-1:0] sum_in;
		sample_t          p_in;
		logic             zero_in;
		logic [RAD_W-1:0] rad;
		logic [RM_W+1:0]  cur;
		logic [RM_W+1:0]  trial;
		logic [RM_W+1:0]  diff;
		logic             ge;

		if (j == 0) begin : g_first
			assign root_in = '0;
			assign rem_in  = '0;
			assign sum_in  = sum_s2;
			assign p_in    = p_s2;
			assign zero_in = zero_s2;
		end else begin : g_next
			assign root_in = root_sq_s[j-1];
			assign rem_in  = rem_sq_s[j-1];
			assign sum_in  = sum_sq_s[j-1];
			assign p_in    = p_sq_s[j-1];
			assign zero_in = zero_sq_s[j-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign rad   = {sum_in, 16'd0};
		assign cur   = {rem_in, rad[2*(SQRT_STEPS-1-j)+1 -: 2]};
		assign trial = {{(RM_W-RT_W){1'b0}}, root_in, 2'b01};
		assign ge    = (cur >= trial);
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sq_s[j]  <= ge ? diff[RM_W-1:0] : cur[RM_W-1:0];
				root_sq_s[j] <= {root_in[RT_W-2:0], ge};
				sum_sq_s[j]  <= sum_in;
				p_sq_s[j]    <= p_in;
				zero_sq_s[j] <= zero_in;
			end
		end
	end

	for (genvar i = 0; i < CR_STEPS; i++) begin : g_cordic
		logic signed [VEC_W-1:0] cx_in;
		logic signed [VEC_W-1:0] cy_in;
		logic signed [ANG_W-1:0] ang_in;
		logic                    zero_in;
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		logic signed [ANG_W-1:0] step;
		logic                    pos;

		if (i == 0) begin : g_first
			assign cx_in   = $signed({{(VEC_W-RT_W){1'b0}}, root_sq_s[SQRT_STEPS-1]});
			assign cy_in   = $signed({{(VEC_W-SAMPLE_W-8){p_sq_s[SQRT_STEPS-1][SAMPLE_W-1]}},
				p_sq_s[SQRT_STEPS-1], 8'd0});
			assign ang_in  = '0;
			assign zero_in = zero_sq_s[SQRT_STEPS-1];
		end else begin : g_next
			assign cx_in   = cx_cr_s[i-1];
			assign cy_in   = cy_cr_s[i-1];
			assign ang_in  = ang_cr_s[i-1];
			assign zero_in = zero_cr_s[i-1];
		end

		assign dx   = cy_in >>> i;
		assign dy   = cx_in >>> i;
		assign step = $signed({{(ANG_W-ATAN_W){1'b0}}, ATAN_DEG_Q16[i]});
		assign pos  = ~cy_in[VEC_W-1];

		always_ff @(posedge clk) begin
			if (en) begin
				ang_cr_s[i]  <= pos ? ang_in + step : ang_in - step;
				zero_cr_s[i] <= zero_in;
			end
		end

		if (i < CR_STEPS - 1) begin : g_vec
			always_ff @(posedge clk) begin
				if (en) begin
					cx_cr_s[i] <= pos ? cx_in + dx : cx_in - dx;
					cy_cr_s[i] <= pos ? cy_in - dy : cy_in + dy;
				end
			end
		end
	end

	// Negate, round half up to 8 fraction bits, then clamp to a quarter turn, or give zero when p is zero.
	assign neg_ang = HALF_LSB - {ang_cr_s[CR_STEPS-1][ANG_W-1], ang_cr_s[CR_STEPS-1]};
	assign deg_sh  = neg_ang[ANG_W:8];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_cr_s[CR_STEPS-1]) begin
				rot_slast <= '0;
			end else if (deg_sh > HI_LIM) begin
				rot_slast <= HI_LIM[ANGLE_W-1:0];
			end else if (deg_sh < LO_LIM) begin
				rot_slast <= LO_LIM[ANGLE_W-1:0];
			end else begin
				rot_slast <= deg_sh[ANGLE_W-1:0];
			end
		end
	end

	assign rot = rot_slast;

endmodule

FILE: rtl/core/accel_tilt_angles.sv
// Throughput: one sample per cycle; the whole pipeline advances together and holds
// only while a result waits in the output stage and the output side is not ready.
// Depth is set by the square root (one stage per root bit) and the CORDIC stages.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module accel_tilt_angles (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [ata_pkg::IN_W-1:0] s_tdata,  // accel_x, accel_y, accel_z
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [ata_pkg::OUT_W-1:0] m_tdata  // x_rotation, y_rotation
);
	import ata_pkg::*;

	sample_t              accel_x;
	sample_t              accel_y;
	sample_t              accel_z;
	angle_t               x_rotation;
	angle_t               y_rotation;
	logic                 en;
	logic [LATENCY-1:0]   vld_q;

	assign accel_x = s_tdata[SAMPLE_W-1:0];
	assign accel_y = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign accel_z = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

	assign en       = ~vld_q[LATENCY-1] | m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LATENCY-1];
	assign m_tdata  = {y_rotation, x_rotation};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], s_tvalid};
		end
	end

	ata_tilt u_x_rot (
		.clk (clk),
		.en  (en),
		.p   (accel_y),
		.a   (accel_x),
		.b   (accel_z),
		.rot (x_rotation)
	);

	ata_tilt u_y_rot (
		.clk (clk),
		.en  (en),
		.p   (accel_x),
		.a   (accel_y),
		.b   (accel_z),
		.rot (y_rotation)
	);

endmodule

FILE: rtl/core/ata_checker.sv
// Port-level checks of the tilt angle block and the bind that attaches them.
`timescale 1ns / 1ps

module ata_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [ata_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ata_pkg::OUT_W-1:0] m_tdata
);
	import ata_pkg::*;

	localparam logic signed [ANGLE_W-1:0] HI_LIM = ANGLE_W'(DEG_LIMIT);
	localparam logic signed [ANGLE_W-1:0] LO_LIM = -HI_LIM;

	// A result that is not taken stays put with the same data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	// The input side is only held off while a result is stalled at the output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back pressure");

	// Both angles stay within a quarter turn.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[ANGLE_W-1:0]) <= HI_LIM
			&& $signed(m_tdata[ANGLE_W-1:0]) >= LO_LIM
			&& $signed(m_tdata[2*ANGLE_W-1:ANGLE_W]) <= HI_LIM
			&& $signed(m_tdata[2*ANGLE_W-1:ANGLE_W]) >= LO_LIM)
		else $error("tilt angle out of range");

	// An offered input transaction waits unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input transaction changed while stalled");

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
